// File: rtl/atu_pkg.sv
// ----------------------------------------------------------------------------
// atu_pkg
// Shared types and constants of the alarm table unit: operation and status
// codes, field widths and the query item that walks the cell chain.
// ----------------------------------------------------------------------------
package atu_pkg;

   localparam int OP_W     = 2;
   localparam int ID_W     = 32;
   localparam int SEV_W    = 3;
   localparam int STATUS_W = 2;
   localparam int TOTAL_W  = 5;

   typedef enum logic [OP_W-1:0] {
      OP_RAISE = 2'd0,
      OP_ACK   = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef struct packed {
      logic              valid;
      op_type            op;
      logic [ID_W-1:0]   alarm_id;
      logic [SEV_W-1:0]  severity;
      logic              sev_ok;
      logic              found;
      logic              appended;
   } query_type;

endpackage

// File: rtl/atu_if.sv
// ----------------------------------------------------------------------------
// atu_req_if / atu_rsp_if
// Valid/ready channels of the alarm table unit.
// ----------------------------------------------------------------------------
interface atu_req_if import atu_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OP_W-1:0]  operation;
   logic [ID_W-1:0]  alarm_id;
   logic [SEV_W-1:0] severity;

   modport source (output valid, operation, alarm_id, severity, input ready);
   modport sink   (input valid, operation, alarm_id, severity, output ready);
endinterface

interface atu_rsp_if import atu_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [TOTAL_W-1:0]  active_total;
   logic [TOTAL_W-1:0]  stored_total;

   modport source (output valid, status, active_total, stored_total, input ready);
   modport sink   (input valid, status, active_total, stored_total, output ready);
endinterface

// File: rtl/atu_cell.sv
// ----------------------------------------------------------------------------
// atu_cell
// One table entry. A query item passes through the cell's register: the cell
// matches the id, applies the operation, takes an append when it is the
// first free slot, and adds its active flag to the running count.
// ----------------------------------------------------------------------------
module atu_cell import atu_pkg::*; #(
   parameter int INDEX = 0,
   parameter int CW    = 5
) (
   input  logic          clock,
   input  logic          reset,
   input  query_type     up_q,
   input  logic [CW-1:0] up_cnt,
   input  logic [CW-1:0] count,
   output query_type     dn_q,
   output logic [CW-1:0] dn_cnt
);

   logic [ID_W-1:0]  id_ff, id_in;
   logic [SEV_W-1:0] sev_ff, sev_in;
   logic             active_ff, active_in;
   logic             acked_ff, acked_in;
   query_type        q_ff, q_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             stored, slot_free, hit, append;

   always_comb begin
      stored    = CW'(INDEX) < count;
      slot_free = CW'(INDEX) == count;
      hit       = up_q.valid && stored && !up_q.found && (up_q.alarm_id == id_ff);
      append    = up_q.valid && slot_free && !up_q.found &&
                  (up_q.op == OP_RAISE) && up_q.sev_ok;

      id_in     = id_ff;
      sev_in    = sev_ff;
      active_in = active_ff;
      acked_in  = acked_ff;
      q_in      = up_q;

      if (hit) begin
         q_in.found = 1'b1;
         case (up_q.op)
            OP_RAISE: begin
               if (up_q.sev_ok) begin
                  active_in = 1'b1;
                  sev_in    = up_q.severity;
               end
            end
            OP_ACK:   acked_in  = 1'b1;
            OP_CLEAR: active_in = 1'b0;
            default: ;
         endcase
      end

      if (append) begin
         id_in         = up_q.alarm_id;
         sev_in        = up_q.severity;
         active_in     = 1'b1;
         acked_in      = 1'b0;
         q_in.found    = 1'b1;
         q_in.appended = 1'b1;
      end

      cnt_in = up_cnt + CW'((stored || append) && active_in);
   end

   always_ff @(posedge clock) begin
      id_ff  <= id_in;
      sev_ff <= sev_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         active_ff <= 1'b0;
         acked_ff  <= 1'b0;
         q_ff      <= '0;
      end else begin
         active_ff <= active_in;
         acked_ff  <= acked_in;
         q_ff      <= q_in;
      end
   end

   assign dn_q   = q_ff;
   assign dn_cnt = cnt_ff;

endmodule

// File: rtl/alarm_table_unit.sv
// ----------------------------------------------------------------------------
// alarm_table_unit
// Append-only alarm table built as a chain of entry cells.
//
//   channel   dir   handshake          payload
//   req_ch    in    valid / ready      operation, alarm_id, severity
//   rsp_ch    out   valid / ready      status, active_total, stored_total
//
// An item walks the chain one cell per cycle and its result is registered
// after the last cell; no new item is taken until the previous result has
// left the holding register for the output register. One item is in the chain
// at a time; a finished result waits in the output register while the next
// item runs. Synchronous reset empties the table at once. A stalled result
// holds the next finished one in a holding register, and the input, until it
// drains.
// ----------------------------------------------------------------------------
module alarm_table_unit import atu_pkg::*; #(
   parameter int MAX_ENTRIES      = 16,
   parameter int HIGHEST_SEVERITY = 4
) (
   input logic       clock,
   input logic       reset,
   atu_req_if.sink   req_ch,
   atu_rsp_if.source rsp_ch
);

   localparam int CW = $clog2(MAX_ENTRIES + 1);

   query_type     q   [0:MAX_ENTRIES];
   logic [CW-1:0] cnt [0:MAX_ENTRIES];

   logic [CW-1:0]       count_ff, count_in;
   logic                busy_ff, busy_in;
   logic                done_valid_ff, done_valid_in;
   status_type          done_status_ff, done_status_in;
   logic [TOTAL_W-1:0]  done_active_ff, done_active_in;
   logic [TOTAL_W-1:0]  done_stored_ff, done_stored_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [TOTAL_W-1:0]  rsp_active_ff, rsp_active_in;
   logic [TOTAL_W-1:0]  rsp_stored_ff, rsp_stored_in;
   logic                accept, move;
   query_type           tail;

   assign req_ch.ready = !busy_ff;
   assign accept       = req_ch.valid && !busy_ff;

   always_comb begin
      q[0].valid    = accept;
      q[0].op       = op_type'(req_ch.operation);
      q[0].alarm_id = req_ch.alarm_id;
      q[0].severity = req_ch.severity;
      q[0].sev_ok   = req_ch.severity <= SEV_W'(HIGHEST_SEVERITY);
      q[0].found    = 1'b0;
      q[0].appended = 1'b0;
      cnt[0]        = '0;
   end

   for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
      atu_cell #(
         .INDEX (k),
         .CW    (CW)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .up_q   (q[k]),
         .up_cnt (cnt[k]),
         .count  (count_ff),
         .dn_q   (q[k+1]),
         .dn_cnt (cnt[k+1])
      );
   end

   assign tail = q[MAX_ENTRIES];
   assign move = done_valid_ff && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      count_in       = count_ff;
      busy_in        = busy_ff;
      done_valid_in  = done_valid_ff;
      done_status_in = done_status_ff;
      done_active_in = done_active_ff;
      done_stored_in = done_stored_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_active_in  = rsp_active_ff;
      rsp_stored_in  = rsp_stored_ff;

      if (accept) begin
         busy_in = 1'b1;
      end

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (move) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = done_status_ff;
         rsp_active_in = done_active_ff;
         rsp_stored_in = done_stored_ff;
         done_valid_in = 1'b0;
         busy_in       = 1'b0;
      end

      if (tail.valid) begin
         count_in       = count_ff + CW'(tail.appended);
         done_valid_in  = 1'b1;
         done_active_in = TOTAL_W'(cnt[MAX_ENTRIES]);
         done_stored_in = TOTAL_W'(count_in);
         case (tail.op)
            OP_RAISE: begin
               if (!tail.sev_ok) begin
                  done_status_in = ST_INVALID;
               end else if (tail.found) begin
                  done_status_in = ST_OK;
               end else begin
                  done_status_in = ST_FULL;
               end
            end
            OP_ACK, OP_CLEAR: done_status_in = tail.found ? ST_OK : ST_INVALID;
            default:          done_status_in = ST_INVALID;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      done_status_ff <= done_status_in;
      done_active_ff <= done_active_in;
      done_stored_ff <= done_stored_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_active_ff  <= rsp_active_in;
      rsp_stored_ff  <= rsp_stored_in;
      if (reset) begin
         count_ff      <= '0;
         busy_ff       <= 1'b0;
         done_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         busy_ff       <= busy_in;
         done_valid_ff <= done_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.active_total = rsp_active_ff;
   assign rsp_ch.stored_total = rsp_stored_ff;

endmodule

// File: tb/sv/alarm_table_checker.sv
// ----------------------------------------------------------------------------
// alarm_table_checker
// Watches both channels of the alarm table unit. Each accepted item updates a
// private copy of the table and queues the expected result. Each accepted
// result is compared field by field with the oldest queued one. Mismatches
// and results nobody asked for are counted.
// ----------------------------------------------------------------------------
module alarm_table_checker import atu_pkg::*; #(
   parameter int MAX_ENTRIES      = 16,
   parameter int HIGHEST_SEVERITY = 4
) (
   input  logic clock,
   input  logic reset,
   atu_req_if   req_ch,
   atu_rsp_if   rsp_ch,
   output int   failures,
   output int   pending,
   output int   checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      status_type         status;
      logic [TOTAL_W-1:0] active_total;
      logic [TOTAL_W-1:0] stored_total;
   } alarm_summary_type;

   logic [ID_W-1:0]   table_ids [MAX_ENTRIES];
   logic [SEV_W-1:0]  table_sev [MAX_ENTRIES];
   logic              table_active [MAX_ENTRIES];
   logic              table_acked [MAX_ENTRIES];
   int unsigned       table_fill;
   alarm_summary_type expected_summaries [$];
   alarm_summary_type due;

   function automatic alarm_summary_type apply_alarm_event(logic [OP_W-1:0] op,
                                                           logic [ID_W-1:0] id,
                                                           logic [SEV_W-1:0] sev);
      alarm_summary_type s;
      int slot;
      int unsigned live;
      slot = -1;
      live = 0;
      for (int k = 0; k < MAX_ENTRIES; k++) begin
         if (k < table_fill && slot < 0 && table_ids[k] == id) slot = k;
      end
      s.status = ST_INVALID;
      if (op == OP_RAISE) begin
         if (sev <= HIGHEST_SEVERITY) begin
            if (slot >= 0) begin
               table_active[slot] = 1'b1;
               table_sev[slot]    = sev;
               s.status           = ST_OK;
            end else if (table_fill >= MAX_ENTRIES) begin
               s.status = ST_FULL;
            end else begin
               table_ids[table_fill]    = id;
               table_sev[table_fill]    = sev;
               table_active[table_fill] = 1'b1;
               table_acked[table_fill]  = 1'b0;
               table_fill++;
               s.status = ST_OK;
            end
         end
      end else if (op == OP_ACK) begin
         if (slot >= 0) begin
            table_acked[slot] = 1'b1;
            s.status          = ST_OK;
         end
      end else if (op == OP_CLEAR) begin
         if (slot >= 0) begin
            table_active[slot] = 1'b0;
            s.status           = ST_OK;
         end
      end
      for (int k = 0; k < MAX_ENTRIES; k++) begin
         if (k < table_fill && table_active[k]) live++;
      end
      s.active_total = TOTAL_W'(live);
      s.stored_total = TOTAL_W'(table_fill);
      return s;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         table_fill = 0;
         for (int k = 0; k < MAX_ENTRIES; k++) begin
            table_active[k] = 1'b0;
            table_acked[k]  = 1'b0;
         end
         expected_summaries.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            checked++;
            if (expected_summaries.size() == 0) begin
               $error("unexpected result: status %0d active %0d stored %0d",
                      rsp_ch.status, rsp_ch.active_total, rsp_ch.stored_total);
               failures++;
            end else begin
               due = expected_summaries.pop_front();
               if (rsp_ch.status !== due.status) begin
                  $error("status: expected %0d, got %0d", due.status, rsp_ch.status);
                  failures++;
               end
               if (rsp_ch.active_total !== due.active_total) begin
                  $error("active_total: expected %0d, got %0d",
                         due.active_total, rsp_ch.active_total);
                  failures++;
               end
               if (rsp_ch.stored_total !== due.stored_total) begin
                  $error("stored_total: expected %0d, got %0d",
                         due.stored_total, rsp_ch.stored_total);
                  failures++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            expected_summaries.push_back(apply_alarm_event(req_ch.operation,
                                                           req_ch.alarm_id,
                                                           req_ch.severity));
         end
      end
      pending = expected_summaries.size();
   end

endmodule

// File: tb/sv/alarm_table_unit_test.sv
// ----------------------------------------------------------------------------
// alarm_table_unit_test
// Drives raise, acknowledge, clear and unused-code items into the alarm table
// unit with random gaps and result stalls, including one long result hold-off
// that backs up the input. A directed opening fills the table to the top and
// touches every corner case; random traffic then works the stored ids.
// ----------------------------------------------------------------------------
module alarm_table_unit_test import atu_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_ENTRIES      = 16;
   localparam int HIGHEST_SEVERITY = 4;
   localparam int SEV_MAX          = (1 << SEV_W) - 1;
   localparam int RANDOM_ITEMS     = 650;
   localparam int IDLE_LIMIT       = 3000;
   localparam int HOLD_CYCLES      = 300;
   localparam int DRAIN_CYCLES     = 4 * (MAX_ENTRIES + 2);
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   hold_results = 1'b0;
   int   failures, pending, checked;
   int   op_tally [4];
   int   calm_left;
   logic [ID_W-1:0] raised_ids [$];

   atu_req_if alarm_req ();
   atu_rsp_if alarm_rsp ();

   alarm_table_unit #(
      .MAX_ENTRIES      (MAX_ENTRIES),
      .HIGHEST_SEVERITY (HIGHEST_SEVERITY)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (alarm_req),
      .rsp_ch (alarm_rsp)
   );

   alarm_table_checker #(
      .MAX_ENTRIES      (MAX_ENTRIES),
      .HIGHEST_SEVERITY (HIGHEST_SEVERITY)
   ) u_checker (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (alarm_req),
      .rsp_ch   (alarm_rsp),
      .failures (failures),
      .pending  (pending),
      .checked  (checked)
   );

   always #10 clock = ~clock;

   initial begin
      alarm_req.valid     = 1'b0;
      alarm_req.operation = OP_RAISE;
      alarm_req.alarm_id  = '0;
      alarm_req.severity  = '0;
      alarm_rsp.ready     = 1'b0;
   end

   function automatic int next_gap();
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) calm_left = $urandom_range(10, 30);
      if (r < 45) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_alarm_event(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                   logic [SEV_W-1:0] sev, int gap);
      if (gap > 0) begin
         alarm_req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      alarm_req.valid     <= 1'b1;
      alarm_req.operation <= op;
      alarm_req.alarm_id  <= id;
      alarm_req.severity  <= sev;
      op_tally[op]++;
      do @(posedge clock); while (!alarm_req.ready);
      @(negedge clock);
   endtask

   task automatic send_random_item(int gap);
      logic [OP_W-1:0]  op;
      logic [ID_W-1:0]  id;
      logic [SEV_W-1:0] sev;
      int r;
      r   = $urandom_range(0, 99);
      op  = OP_W'($urandom_range(OP_RAISE, OP_CLEAR));
      sev = ($urandom_range(0, 4) == 0) ? SEV_W'($urandom_range(HIGHEST_SEVERITY + 1, SEV_MAX))
                                        : SEV_W'($urandom_range(0, HIGHEST_SEVERITY));
      if (r < 85) id = raised_ids[$urandom_range(0, raised_ids.size() - 1)];
      else id = $urandom();
      if (r >= 95) begin
         op  = OP_UNUSED;
         sev = SEV_W'($urandom_range(0, SEV_MAX));
      end
      send_alarm_event(op, id, sev, gap);
   endtask

   // receiver: ready streaks, short and long stalls, one long hold on request
   initial begin
      int n;
      bit lvl;
      while (reset) @(negedge clock);
      forever begin
         if (hold_results) begin
            hold_results = 1'b0;
            lvl = 1'b0;
            n   = HOLD_CYCLES;
         end else if ($urandom_range(0, 99) < 65) begin
            lvl = 1'b1;
            n   = $urandom_range(1, 25);
         end else begin
            lvl = 1'b0;
            n   = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(15, 60);
         end
         alarm_rsp.ready <= lvl;
         repeat (n) @(negedge clock);
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((alarm_req.valid && alarm_req.ready) || (alarm_rsp.valid && alarm_rsp.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      logic [ID_W-1:0] id;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty table, bad severities, unused code, extreme ids
      send_alarm_event(OP_ACK, 32'd5, SEV_W'($urandom_range(0, SEV_MAX)), next_gap());
      send_alarm_event(OP_RAISE, 32'h0000_0000, 3'd0, next_gap());
      send_alarm_event(OP_RAISE, 32'hFFFF_FFFF, SEV_W'(HIGHEST_SEVERITY), next_gap());
      send_alarm_event(OP_RAISE, 32'd7, SEV_W'(HIGHEST_SEVERITY + 1), next_gap());
      send_alarm_event(OP_RAISE, 32'd7, SEV_W'(SEV_MAX), next_gap());
      send_alarm_event(OP_UNUSED, 32'h0000_0000, SEV_W'(SEV_MAX), next_gap());
      send_alarm_event(OP_ACK, 32'hFFFF_FFFF, 3'd0, next_gap());
      send_alarm_event(OP_CLEAR, 32'hFFFF_FFFF, SEV_W'(SEV_MAX), next_gap());
      // re-raise keeps the ack flag
      send_alarm_event(OP_RAISE, 32'hFFFF_FFFF, 3'd2, next_gap());
      send_alarm_event(OP_ACK, 32'h0000_0000, 3'd0, next_gap());
      send_alarm_event(OP_CLEAR, 32'h0000_0000, 3'd0, next_gap());
      send_alarm_event(OP_CLEAR, 32'h0001_2345, 3'd0, next_gap());
      raised_ids.push_back(32'h0000_0000);
      raised_ids.push_back(32'hFFFF_FFFF);
      for (int k = 1; k < MAX_ENTRIES - 1; k++) begin
         id = {4'(k), 28'($urandom())};
         raised_ids.push_back(id);
         send_alarm_event(OP_RAISE, id, SEV_W'($urandom_range(0, HIGHEST_SEVERITY)),
                          next_gap());
      end
      // table full: new id refused, stored id still accepted
      send_alarm_event(OP_RAISE, 32'hF000_0000, 3'd1, next_gap());
      send_alarm_event(OP_RAISE, raised_ids[3], 3'd3, next_gap());

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2) begin
            hold_results = 1'b1;
            repeat (12) send_random_item(0);
         end
         send_random_item(next_gap());
      end
      alarm_req.valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Run covered %0d items: %0d raise, %0d acknowledge, %0d clear, %0d unused code",
               op_tally[OP_RAISE] + op_tally[OP_ACK] + op_tally[OP_CLEAR] + op_tally[OP_UNUSED],
               op_tally[OP_RAISE], op_tally[OP_ACK], op_tally[OP_CLEAR], op_tally[OP_UNUSED]);
      $display("%0d results compared, table filled to %0d entries, %0d mismatches",
               checked, MAX_ENTRIES, failures);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: alarm_table_unit.f
rtl/atu_pkg.sv
rtl/atu_if.sv
rtl/atu_cell.sv
rtl/alarm_table_unit.sv
tb/sv/alarm_table_checker.sv
tb/sv/alarm_table_unit_test.sv
